>>> rtl/vdcs_pkg.sv
// ----------------------------------------------------------------------------
// vdcs_pkg
// Types, register map and helpers shared by the drive and cooling supervisor.
// ----------------------------------------------------------------------------
package vdcs_pkg;

  localparam int unsigned PCT_W   = 7;
  localparam int unsigned PRESS_W = 16;
  localparam int unsigned TEMP_W  = 9;   // signed degrees, -40 .. 225
  localparam int unsigned PROD_W  = 15;  // diff * 100 fits below 2**15
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_COOL_START = 3'd0;
  localparam logic [2:0] REG_FULL_COOL  = 3'd1;
  localparam logic [2:0] REG_SHUTDOWN   = 3'd2;
  localparam logic [2:0] REG_P_LOW      = 3'd3;
  localparam logic [2:0] REG_P_HIGH     = 3'd4;
  localparam logic [2:0] REG_PUMP_MIN   = 3'd5;
  localparam logic [2:0] REG_BRAKE_THR  = 3'd6;

  // reset values
  localparam logic [PCT_W-1:0]   RST_COOL_START = 7'd40;
  localparam logic [PCT_W-1:0]   RST_FULL_COOL  = 7'd55;
  localparam logic [PCT_W-1:0]   RST_SHUTDOWN   = 7'd60;
  localparam logic [PRESS_W-1:0] RST_P_LOW      = 16'd10000;
  localparam logic [PRESS_W-1:0] RST_P_HIGH     = 16'd30000;
  localparam logic [PCT_W-1:0]   RST_PUMP_MIN   = 7'd50;
  localparam logic [PCT_W-1:0]   RST_BRAKE_THR  = 7'd10;

  // direction command codes
  localparam logic [1:0] DIR_NONE    = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;

  typedef enum logic [1:0] {
    DRV_ERROR   = 2'd0,
    DRV_FORWARD = 2'd1,
    DRV_REVERSE = 2'd2
  } drive_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAX,
    S_PREP,
    S_DIV,
    S_DONE
  } seq_t;

  typedef struct packed {
    logic [31:0]        drive_temps_raw;
    logic signed [7:0]  coolant_temp_a;
    logic signed [7:0]  coolant_temp_b;
    logic [15:0]        pressure_a;
    logic [15:0]        pressure_b;
    logic [18:0]        fault_bits;
    logic [2:0]         driver_bits;
    logic [15:0]        wheel_speeds;
    logic [6:0]         accel_travel_a;
    logic [6:0]         accel_travel_b;
    logic [6:0]         brake_travel;
  } in_item_t;

  typedef struct packed {
    logic [6:0] fan_percent;
    logic [6:0] pump_percent;
    logic       shutdown_cmd;
    logic [1:0] direction_cmd;
    logic       throttle_valid;
    logic [6:0] throttle_percent;
    logic       brake_light;
    logic       inverter_fault;
    logic       car_running;
    logic       car_in_reverse;
  } out_item_t;

  // Temperature source i of a snapshot, in degrees.
  function automatic logic signed [TEMP_W-1:0] temp_at(in_item_t it, logic [2:0] i);
    logic signed [TEMP_W-1:0] t;
    t = '0;
    case (i)
      3'd0: t = $signed({1'b0, it.drive_temps_raw[7:0]})   - 9'sd30;
      3'd1: t = $signed({1'b0, it.drive_temps_raw[15:8]})  - 9'sd30;
      3'd2: t = $signed({1'b0, it.drive_temps_raw[23:16]}) - 9'sd40;
      3'd3: t = $signed({1'b0, it.drive_temps_raw[31:24]}) - 9'sd40;
      3'd4: t = it.coolant_temp_a[7] ? '0 : $signed({1'b0, it.coolant_temp_a});
      3'd5: t = it.coolant_temp_b[7] ? '0 : $signed({1'b0, it.coolant_temp_b});
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [PCT_W-1:0] sat100(logic [PCT_W-1:0] v);
    return (v > PCT_FULL) ? PCT_FULL : v;
  endfunction

endpackage

>>> rtl/vehicle_drive_and_cooling_supervisor_unit.sv
// ----------------------------------------------------------------------------
// vehicle_drive_and_cooling_supervisor_unit
// Cooling control, direction machine and throttle from one loop snapshot.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one snapshot per
//   request; output channel (out_valid / out_stall / out_data) returns one
//   result per snapshot, in order. The user sets limits over the APB-style
//   port (psel, penable, pwrite, paddr, pwdata, prdata, pready) only while
//   idle; the block itself does not enforce this.
// Timing:
//   One shared signed comparator scans the six temperatures in S_MAX, a
//   setup step (S_PREP) scales the excess by 100, then a restoring divider
//   (S_DIV) retires one quotient bit per cycle. S_DONE loads the result into
//   the output register, and a new snapshot is taken once the sequencer is
//   back in S_IDLE. With the fans off or pinned at full the divider is
//   skipped. in_stall is high while in work.
// Stall:
//   The output register holds its result while out_stall is high; a new
//   snapshot is still accepted, and its finished result waits in the last
//   sequencer step until the output register frees up.
// Reset:
//   rst_n (synchronous) loads the default limits, puts the direction machine
//   in forward, clears the held pump drive and empties the output register.
// ----------------------------------------------------------------------------
module vehicle_drive_and_cooling_supervisor_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  vdcs_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output vdcs_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vdcs_pkg::ADDR_W-1:0]   paddr,
  input  logic [vdcs_pkg::DATA_W-1:0]   pwdata,
  output logic [vdcs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned PCT_W   = vdcs_pkg::PCT_W;
  localparam int unsigned PRESS_W = vdcs_pkg::PRESS_W;
  localparam int unsigned TEMP_W  = vdcs_pkg::TEMP_W;
  localparam int unsigned PROD_W  = vdcs_pkg::PROD_W;
  localparam int unsigned DATA_W  = vdcs_pkg::DATA_W;

  // configuration
  logic [PCT_W-1:0]   cool_start_r, full_cool_r, shutdown_r, pump_min_r, brake_thr_r;
  logic [PRESS_W-1:0] p_low_r, p_high_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  // sequencer and datapath
  vdcs_pkg::seq_t            state_r, state_nxt;
  vdcs_pkg::in_item_t        item_r, item_nxt;
  logic [2:0]                idx_r, idx_nxt;
  logic signed [TEMP_W-1:0]  hot_r, hot_nxt;
  logic                      active_r, active_nxt;
  logic                      degen_r, degen_nxt;
  logic [3:0]                cnt_r, cnt_nxt;
  logic [PROD_W-1:0]         quo_r, quo_nxt;
  logic [PCT_W-1:0]          rem_r, rem_nxt;
  logic [PCT_W-1:0]          span_r, span_nxt;
  vdcs_pkg::drive_t          drive_r, drive_nxt;
  logic [PCT_W-1:0]          held_r, held_nxt;
  vdcs_pkg::out_item_t       out_r, out_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // temperature select, divider compare / subtract unit and result terms
  logic signed [TEMP_W-1:0]  t_cur;
  logic [PCT_W:0]            rem_sh;
  logic                      div_ge;
  logic [PCT_W:0]            rem_sub;
  logic [7:0]                diff;
  logic [PCT_W-1:0]          fan_c, pmin_c, pump_c, acc_a, acc_b, thr_c;
  logic                      p_bad, errors, brake_on, run_c, commit;
  vdcs_pkg::drive_t          drive_c;
  logic [1:0]                dir_c;
  logic                      shut_c;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cool_start_r <= vdcs_pkg::RST_COOL_START;
      full_cool_r  <= vdcs_pkg::RST_FULL_COOL;
      shutdown_r   <= vdcs_pkg::RST_SHUTDOWN;
      p_low_r      <= vdcs_pkg::RST_P_LOW;
      p_high_r     <= vdcs_pkg::RST_P_HIGH;
      pump_min_r   <= vdcs_pkg::RST_PUMP_MIN;
      brake_thr_r  <= vdcs_pkg::RST_BRAKE_THR;
    end else if (cfg_wr) begin
      case (cfg_idx)
        vdcs_pkg::REG_COOL_START: cool_start_r <= pwdata[PCT_W-1:0];
        vdcs_pkg::REG_FULL_COOL:  full_cool_r  <= pwdata[PCT_W-1:0];
        vdcs_pkg::REG_SHUTDOWN:   shutdown_r   <= pwdata[PCT_W-1:0];
        vdcs_pkg::REG_P_LOW:      p_low_r      <= pwdata[PRESS_W-1:0];
        vdcs_pkg::REG_P_HIGH:     p_high_r     <= pwdata[PRESS_W-1:0];
        vdcs_pkg::REG_PUMP_MIN:   pump_min_r   <= pwdata[PCT_W-1:0];
        vdcs_pkg::REG_BRAKE_THR:  brake_thr_r  <= pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      vdcs_pkg::REG_COOL_START: prdata = DATA_W'(cool_start_r);
      vdcs_pkg::REG_FULL_COOL:  prdata = DATA_W'(full_cool_r);
      vdcs_pkg::REG_SHUTDOWN:   prdata = DATA_W'(shutdown_r);
      vdcs_pkg::REG_P_LOW:      prdata = DATA_W'(p_low_r);
      vdcs_pkg::REG_P_HIGH:     prdata = DATA_W'(p_high_r);
      vdcs_pkg::REG_PUMP_MIN:   prdata = DATA_W'(pump_min_r);
      vdcs_pkg::REG_BRAKE_THR:  prdata = DATA_W'(brake_thr_r);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- datapath terms
  assign t_cur   = vdcs_pkg::temp_at(item_r, idx_r);
  assign rem_sh  = {rem_r, quo_r[PROD_W-1]};
  assign div_ge  = rem_sh >= {1'b0, span_r};
  assign rem_sub = rem_sh - {1'b0, span_r};
  assign diff    = 8'(hot_r - $signed({2'b00, cool_start_r}));

  always_comb begin
    if (!active_r) begin
      fan_c = '0;
    end else if (degen_r) begin
      fan_c = vdcs_pkg::PCT_FULL;
    end else if (quo_r > PROD_W'(vdcs_pkg::PCT_FULL)) begin
      fan_c = vdcs_pkg::PCT_FULL;
    end else begin
      fan_c = quo_r[PCT_W-1:0];
    end
    pmin_c = vdcs_pkg::sat100(pump_min_r);
    p_bad  = (item_r.pressure_a < p_low_r) || (item_r.pressure_b < p_low_r) ||
             (item_r.pressure_a > p_high_r) || (item_r.pressure_b > p_high_r);
    if (!active_r) begin
      pump_c = held_r;
    end else if (p_bad) begin
      pump_c = '0;
    end else begin
      pump_c = (fan_c <= pmin_c) ? pmin_c : fan_c;
    end

    errors = (|item_r.fault_bits) || !item_r.driver_bits[0] ||
             (hot_r >= $signed({2'b00, shutdown_r}));
    shut_c  = 1'b0;
    dir_c   = vdcs_pkg::DIR_NONE;
    drive_c = drive_r;
    case (drive_r)
      vdcs_pkg::DRV_FORWARD: begin
        if (errors || item_r.driver_bits[1]) begin
          shut_c  = 1'b1;
          drive_c = vdcs_pkg::DRV_ERROR;
        end
      end
      vdcs_pkg::DRV_REVERSE: begin
        if (errors || !item_r.driver_bits[1]) begin
          shut_c  = 1'b1;
          drive_c = vdcs_pkg::DRV_ERROR;
        end
      end
      default: begin
        drive_c = vdcs_pkg::DRV_ERROR;
        if (!errors && item_r.wheel_speeds == '0) begin
          if (item_r.driver_bits[1]) begin
            dir_c   = vdcs_pkg::DIR_REVERSE;
            drive_c = vdcs_pkg::DRV_REVERSE;
          end else begin
            dir_c   = vdcs_pkg::DIR_FORWARD;
            drive_c = vdcs_pkg::DRV_FORWARD;
          end
        end
      end
    endcase

    brake_on = item_r.brake_travel >= brake_thr_r;
    run_c    = (drive_c == vdcs_pkg::DRV_FORWARD) || (drive_c == vdcs_pkg::DRV_REVERSE);
    acc_a    = vdcs_pkg::sat100(item_r.accel_travel_a);
    acc_b    = vdcs_pkg::sat100(item_r.accel_travel_b);
    thr_c    = '0;
    if (!brake_on && run_c) begin
      thr_c = (acc_a < acc_b) ? acc_a : acc_b;
      if (drive_c == vdcs_pkg::DRV_REVERSE) begin
        thr_c = thr_c >> 1;
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign commit = (state_r == vdcs_pkg::S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    hot_nxt       = hot_r;
    active_nxt    = active_r;
    degen_nxt     = degen_r;
    cnt_nxt       = cnt_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    span_nxt      = span_r;
    drive_nxt     = drive_r;
    held_nxt      = held_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (state_r != vdcs_pkg::S_IDLE);

    case (state_r)
      vdcs_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          hot_nxt   = vdcs_pkg::temp_at(in_data, 3'd0);
          idx_nxt   = 3'd1;
          state_nxt = vdcs_pkg::S_MAX;
        end
      end
      vdcs_pkg::S_MAX: begin
        if (t_cur > hot_r) begin
          hot_nxt = t_cur;
        end
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd5) begin
          state_nxt = vdcs_pkg::S_PREP;
        end
      end
      vdcs_pkg::S_PREP: begin
        active_nxt = hot_r > $signed({2'b00, cool_start_r});
        degen_nxt  = full_cool_r <= cool_start_r;
        span_nxt   = full_cool_r - cool_start_r;
        quo_nxt    = PROD_W'(diff * vdcs_pkg::PCT_FULL);
        rem_nxt    = '0;
        cnt_nxt    = 4'(PROD_W - 1);
        // no division needed when the fans are off or pinned at full
        if (hot_r > $signed({2'b00, cool_start_r}) && full_cool_r > cool_start_r) begin
          state_nxt = vdcs_pkg::S_DIV;
        end else begin
          state_nxt = vdcs_pkg::S_DONE;
        end
      end
      vdcs_pkg::S_DIV: begin
        rem_nxt = div_ge ? rem_sub[PCT_W-1:0] : rem_sh[PCT_W-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], div_ge};
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == '0) begin
          state_nxt = vdcs_pkg::S_DONE;
        end
      end
      vdcs_pkg::S_DONE: begin
        if (commit) begin
          held_nxt                      = pump_c;
          drive_nxt                     = drive_c;
          out_nxt.fan_percent           = fan_c;
          out_nxt.pump_percent          = pump_c;
          out_nxt.shutdown_cmd          = shut_c;
          out_nxt.direction_cmd         = dir_c;
          out_nxt.throttle_valid        = run_c;
          out_nxt.throttle_percent      = thr_c;
          out_nxt.brake_light           = brake_on;
          out_nxt.inverter_fault        = item_r.driver_bits[2] ||
                                          (drive_c == vdcs_pkg::DRV_ERROR);
          out_nxt.car_running           = run_c;
          out_nxt.car_in_reverse        = (drive_c == vdcs_pkg::DRV_REVERSE);
          out_valid_nxt                 = 1'b1;
          state_nxt                     = vdcs_pkg::S_IDLE;
        end
      end
      default: state_nxt = vdcs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vdcs_pkg::S_IDLE;
      drive_r     <= vdcs_pkg::DRV_FORWARD;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drive_r     <= drive_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    idx_r    <= idx_nxt;
    hot_r    <= hot_nxt;
    active_r <= active_nxt;
    degen_r  <= degen_nxt;
    cnt_r    <= cnt_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    span_r   <= span_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------- checks
  a_fan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fan_percent <= vdcs_pkg::PCT_FULL)
    else $error("fan drive above full scale");

  a_thr_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.throttle_valid |-> out_data.throttle_percent == '0)
    else $error("throttle sent while not running");

  a_shutdown_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.shutdown_cmd |-> out_data.inverter_fault && !out_data.car_running)
    else $error("shutdown without error state");

  a_dir_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.direction_cmd != vdcs_pkg::DIR_NONE |->
      out_data.car_running &&
      (out_data.car_in_reverse == (out_data.direction_cmd == vdcs_pkg::DIR_REVERSE)))
    else $error("direction command disagrees with drive state");

  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> state_r == vdcs_pkg::S_IDLE && out_valid_r)
    else $error("finished result not loaded into output register");

endmodule

>>> test/vdcs_checker.sv
// ----------------------------------------------------------------------------
// vdcs_checker
// Watches the snapshot and result channels of the drive and cooling
// supervisor, follows limit writes on the APB-style port, predicts each
// result from its own copy of the limits, direction state and held pump
// drive, and compares every result field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module vdcs_checker
  import vdcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_item_t           out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                pready,
  output int unsigned         fail_count,
  output int unsigned         pending_count,
  output int unsigned         result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PCT_W-1:0]   lim_cool_start;
  logic [PCT_W-1:0]   lim_full_cool;
  logic [PCT_W-1:0]   lim_shutdown;
  logic [PRESS_W-1:0] lim_p_low;
  logic [PRESS_W-1:0] lim_p_high;
  logic [PCT_W-1:0]   lim_pump_min;
  logic [PCT_W-1:0]   lim_brake;

  drive_t             drive_now;
  logic [PCT_W-1:0]   pump_hold;
  out_item_t          supervisor_q[$];

  // Work out one snapshot's result and advance the direction state and pump hold.
  function automatic out_item_t supervise(input in_item_t s);
    int        deg [6];
    int        hottest;
    int        fan;
    int        pump_floor;
    int        acc_a;
    int        acc_b;
    int        thr;
    bit        faulted;
    bit        rev_req;
    bit        shut;
    bit        brake_on;
    bit        running;
    logic [1:0] dir;
    out_item_t r;
    deg[0] = int'(s.drive_temps_raw[7:0]) - 30;
    deg[1] = int'(s.drive_temps_raw[15:8]) - 30;
    deg[2] = int'(s.drive_temps_raw[23:16]) - 40;
    deg[3] = int'(s.drive_temps_raw[31:24]) - 40;
    deg[4] = int'($signed(s.coolant_temp_a));
    deg[5] = int'($signed(s.coolant_temp_b));
    if (deg[4] < 0) deg[4] = 0;
    if (deg[5] < 0) deg[5] = 0;
    hottest = deg[0];
    for (int k = 1; k < 6; k++) begin
      if (deg[k] > hottest) hottest = deg[k];
    end

    fan = 0;
    if (hottest > int'(lim_cool_start)) begin
      if (lim_full_cool > lim_cool_start) begin
        fan = ((hottest - int'(lim_cool_start)) * 100) /
              (int'(lim_full_cool) - int'(lim_cool_start));
        if (fan > 100) fan = 100;
      end else begin
        fan = 100;
      end
      if (s.pressure_a < lim_p_low || s.pressure_b < lim_p_low ||
          s.pressure_a > lim_p_high || s.pressure_b > lim_p_high) begin
        pump_hold = '0;
      end else begin
        pump_floor = (int'(lim_pump_min) > 100) ? 100 : int'(lim_pump_min);
        pump_hold = PCT_W'((fan <= pump_floor) ? pump_floor : fan);
      end
    end

    rev_req = s.driver_bits[1];
    faulted = (s.fault_bits != '0) || !s.driver_bits[0] || (hottest >= int'(lim_shutdown));
    shut = 1'b0;
    dir = DIR_NONE;
    case (drive_now)
      DRV_FORWARD: begin
        if (faulted || rev_req) begin
          shut = 1'b1;
          drive_now = DRV_ERROR;
        end
      end
      DRV_REVERSE: begin
        if (faulted || !rev_req) begin
          shut = 1'b1;
          drive_now = DRV_ERROR;
        end
      end
      default: begin
        drive_now = DRV_ERROR;
        if (!faulted && s.wheel_speeds == '0) begin
          if (rev_req) begin
            dir = DIR_REVERSE;
            drive_now = DRV_REVERSE;
          end else begin
            dir = DIR_FORWARD;
            drive_now = DRV_FORWARD;
          end
        end
      end
    endcase

    brake_on = (s.brake_travel >= lim_brake);
    running = (drive_now == DRV_FORWARD) || (drive_now == DRV_REVERSE);
    thr = 0;
    if (!brake_on) begin
      acc_a = (int'(s.accel_travel_a) > 100) ? 100 : int'(s.accel_travel_a);
      acc_b = (int'(s.accel_travel_b) > 100) ? 100 : int'(s.accel_travel_b);
      thr = (acc_a < acc_b) ? acc_a : acc_b;
      if (drive_now == DRV_REVERSE) thr = thr / 2;
    end
    if (!running) thr = 0;

    r.fan_percent      = PCT_W'(fan);
    r.pump_percent     = pump_hold;
    r.shutdown_cmd     = shut;
    r.direction_cmd    = dir;
    r.throttle_valid   = running;
    r.throttle_percent = PCT_W'(thr);
    r.brake_light      = brake_on;
    r.inverter_fault   = s.driver_bits[2] || (drive_now == DRV_ERROR);
    r.car_running      = running;
    r.car_in_reverse   = (drive_now == DRV_REVERSE);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lim_cool_start = RST_COOL_START;
      lim_full_cool  = RST_FULL_COOL;
      lim_shutdown   = RST_SHUTDOWN;
      lim_p_low      = RST_P_LOW;
      lim_p_high     = RST_P_HIGH;
      lim_pump_min   = RST_PUMP_MIN;
      lim_brake      = RST_BRAKE_THR;
      drive_now      = DRV_FORWARD;
      pump_hold      = '0;
      supervisor_q.delete();
      fail_count     = 0;
      result_count   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_COOL_START: lim_cool_start = pwdata[PCT_W-1:0];
          REG_FULL_COOL:  lim_full_cool  = pwdata[PCT_W-1:0];
          REG_SHUTDOWN:   lim_shutdown   = pwdata[PCT_W-1:0];
          REG_P_LOW:      lim_p_low      = pwdata[PRESS_W-1:0];
          REG_P_HIGH:     lim_p_high     = pwdata[PRESS_W-1:0];
          REG_PUMP_MIN:   lim_pump_min   = pwdata[PCT_W-1:0];
          REG_BRAKE_THR:  lim_brake      = pwdata[PCT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) supervisor_q.push_back(supervise(in_data));
      if (out_valid && !out_stall) begin
        if (supervisor_q.size() == 0) begin
          $display("%0t ns: result with no request pending, expected none, actual %h",
                   $time, out_data);
          fail_count++;
        end else begin
          out_item_t want;
          want = supervisor_q.pop_front();
          check_field("fan_percent", 8'(want.fan_percent), 8'(out_data.fan_percent));
          check_field("pump_percent", 8'(want.pump_percent), 8'(out_data.pump_percent));
          check_field("shutdown_cmd", 8'(want.shutdown_cmd), 8'(out_data.shutdown_cmd));
          check_field("direction_cmd", 8'(want.direction_cmd), 8'(out_data.direction_cmd));
          check_field("throttle_valid", 8'(want.throttle_valid),
                      8'(out_data.throttle_valid));
          check_field("throttle_percent", 8'(want.throttle_percent),
                      8'(out_data.throttle_percent));
          check_field("brake_light", 8'(want.brake_light), 8'(out_data.brake_light));
          check_field("inverter_fault", 8'(want.inverter_fault),
                      8'(out_data.inverter_fault));
          check_field("car_running", 8'(want.car_running), 8'(out_data.car_running));
          check_field("car_in_reverse", 8'(want.car_in_reverse),
                      8'(out_data.car_in_reverse));
          result_count++;
        end
      end
    end
    pending_count = supervisor_q.size();
  end

endmodule

>>> test/vehicle_drive_and_cooling_supervisor_unit_tb.sv
// ----------------------------------------------------------------------------
// vehicle_drive_and_cooling_supervisor_unit_tb
// Drives directed and random control-loop snapshots into the supervisor under
// several limit settings and idle/stall mixes; the checker beside the block
// predicts and compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module vehicle_drive_and_cooling_supervisor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vdcs_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 72;
  localparam logic [2:0] LIMIT_REGS [7] = '{REG_COOL_START, REG_FULL_COOL, REG_SHUTDOWN,
                                            REG_P_LOW, REG_P_HIGH, REG_PUMP_MIN,
                                            REG_BRAKE_THR};

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned result_count;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  int unsigned lim [7];
  int unsigned sent_count = 0;
  bit          want_reverse = 1'b0;

  vehicle_drive_and_cooling_supervisor_unit u_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  vdcs_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending_count, .result_count
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    #4ms;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_snapshot(input in_item_t s);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // Drop the request and let every pending result drain before touching limits.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic program_limits(input int which);
    case (which)
      0: lim = '{40, 55, 60, 10000, 30000, 50, 10};
      1: lim = '{0, 127, 127, 0, 65535, 0, 0};
      2: lim = '{127, 1, 0, 65535, 0, 100, 100};
      3: lim = '{50, 50, 90, 20000, 20000, 30, 50};
      default: begin
        lim[REG_COOL_START] = $urandom_range(0, 80);
        lim[REG_FULL_COOL]  = $urandom_range(1, 127);
        lim[REG_SHUTDOWN]   = $urandom_range(30, 127);
        lim[REG_P_LOW]      = $urandom_range(0, 30000);
        lim[REG_P_HIGH]     = $urandom_range(lim[REG_P_LOW], 65535);
        lim[REG_PUMP_MIN]   = $urandom_range(0, 100);
        lim[REG_BRAKE_THR]  = $urandom_range(0, 100);
      end
    endcase
    for (int i = 0; i < 7; i++) begin
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {LIMIT_REGS[i], 2'b00};
      pwdata  <= lim[LIMIT_REGS[i]];
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // Mostly plausible driving: faults rare, pressures in the window, speeds often zero.
  function automatic in_item_t random_snapshot();
    in_item_t s;
    int       heat;
    if ($urandom_range(0, 3) == 0) begin
      s.drive_temps_raw = $urandom;
      s.coolant_temp_a  = 8'($urandom);
      s.coolant_temp_b  = 8'($urandom);
      s.pressure_a      = 16'($urandom);
      s.pressure_b      = 16'($urandom);
      s.fault_bits      = $urandom_range(0, 1) ? 19'($urandom) : 19'(1) << $urandom_range(0, 18);
      s.driver_bits     = 3'($urandom);
      s.wheel_speeds    = $urandom_range(0, 1) ? 16'($urandom) : 16'h0000;
      s.accel_travel_a  = 7'($urandom);
      s.accel_travel_b  = 7'($urandom);
      s.brake_travel    = 7'($urandom);
    end else begin
      heat = $urandom_range(0, 100);
      s.drive_temps_raw = {8'($urandom_range(0, heat + 40)), 8'($urandom_range(0, heat + 40)),
                           8'($urandom_range(0, heat + 30)), 8'($urandom_range(0, heat + 30))};
      s.coolant_temp_a  = 8'($urandom_range(0, heat + 20)) - 8'd20;
      s.coolant_temp_b  = 8'($urandom_range(0, heat + 20)) - 8'd20;
      if ($urandom_range(0, 9) != 0 && lim[REG_P_LOW] <= lim[REG_P_HIGH]) begin
        s.pressure_a = 16'($urandom_range(lim[REG_P_LOW], lim[REG_P_HIGH]));
        s.pressure_b = 16'($urandom_range(lim[REG_P_LOW], lim[REG_P_HIGH]));
      end else begin
        s.pressure_a = 16'($urandom);
        s.pressure_b = 16'($urandom);
      end
      s.fault_bits = ($urandom_range(0, 19) == 0) ? 19'(1) << $urandom_range(0, 18) : '0;
      if ($urandom_range(0, 9) == 0) want_reverse = !want_reverse;
      s.driver_bits  = {($urandom_range(0, 19) == 0), want_reverse,
                        ($urandom_range(0, 15) != 0)};
      s.wheel_speeds = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom_range(0, 65535));
      s.accel_travel_a = 7'($urandom_range(0, 100));
      s.accel_travel_b = 7'($urandom_range(0, 100));
      s.brake_travel   = 7'($urandom_range(0, 100));
    end
    return s;
  endfunction

  initial begin
    in_item_t s;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    program_limits(0);

    // cool, healthy snapshot while the machine sits in forward
    s.drive_temps_raw = {8'd60, 8'd60, 8'd50, 8'd50};
    s.coolant_temp_a  = 8'sd20;
    s.coolant_temp_b  = 8'sd20;
    s.pressure_a      = 16'd20000;
    s.pressure_b      = 16'd20000;
    s.fault_bits      = '0;
    s.driver_bits     = 3'b001;
    s.wheel_speeds    = 16'h0000;
    s.accel_travel_a  = 7'd50;
    s.accel_travel_b  = 7'd60;
    s.brake_travel    = 7'd0;
    send_snapshot(s);
    s.accel_travel_a = 7'd100; s.accel_travel_b = 7'd100; send_snapshot(s);
    // pedal readings above full travel
    s.accel_travel_a = 7'd127; s.accel_travel_b = 7'd110; send_snapshot(s);
    s.brake_travel = 7'd10; send_snapshot(s);
    s.brake_travel = 7'd0;
    // reverse request in forward, then held in error while wheels turn
    s.driver_bits = 3'b011; s.wheel_speeds = 16'h0101; send_snapshot(s);
    send_snapshot(s);
    s.wheel_speeds = 16'h0000; s.accel_travel_a = 7'd99; s.accel_travel_b = 7'd100;
    send_snapshot(s);
    s.driver_bits = 3'b001; send_snapshot(s);
    send_snapshot(s);
    s.driver_bits = 3'b101; send_snapshot(s);
    s.driver_bits = 3'b001; s.fault_bits = 19'h40000; send_snapshot(s);
    s.fault_bits = '0; s.driver_bits = 3'b000; send_snapshot(s);
    s.driver_bits = 3'b001; send_snapshot(s);
    // hottest possible and coldest possible temperatures
    s.drive_temps_raw = '1; send_snapshot(s);
    s.drive_temps_raw = '0; s.coolant_temp_a = -8'sd128; s.coolant_temp_b = -8'sd1;
    send_snapshot(s);
    s.coolant_temp_a = 8'sd127; send_snapshot(s);
    s.coolant_temp_a = 8'sd0; s.coolant_temp_b = 8'sd41; send_snapshot(s);
    s.coolant_temp_b = 8'sd50; send_snapshot(s);
    s.coolant_temp_b = 8'sd45; s.pressure_a = 16'd9999; send_snapshot(s);
    s.pressure_a = 16'd20000; s.pressure_b = 16'd30001; send_snapshot(s);
    s.coolant_temp_b = 8'sd20; s.pressure_b = 16'd20000; send_snapshot(s);
    s.coolant_temp_b = 8'sd59; s.pressure_a = 16'd10000; s.pressure_b = 16'd30000;
    send_snapshot(s);
    s.coolant_temp_b = 8'sd60; send_snapshot(s);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct  = 0;
      stall_pct = 0;
      program_limits(ph);
      case (ph % 4)
        1: idle_pct = 66;
        2: stall_pct = 66;
        3: begin
          idle_pct  = 16;
          stall_pct = 16;
        end
        default: ;
      endcase
      repeat (PHASE_ITEMS) send_snapshot(random_snapshot());
      drain();
    end

    repeat (40) @(negedge clk);
    $display("Covered %0d snapshots under %0d limit settings and four idle/stall mixes",
             sent_count, PHASES + 1);
    $display("Compared %0d results field by field, %0d mismatches", result_count, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> vehicle_drive_and_cooling_supervisor_unit.f
rtl/vdcs_pkg.sv
rtl/vehicle_drive_and_cooling_supervisor_unit.sv
test/vdcs_checker.sv
test/vehicle_drive_and_cooling_supervisor_unit_tb.sv
